FILE: rtl/gbsp_pkg.sv
`default_nettype none

package gbsp_pkg;

    localparam int DEF_GRID_ROWS = 8;
    localparam int DEF_GRID_COLS = 8;
    localparam int RESULT_LIMIT  = 64;

    // direction that led from a parent into a cell
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef struct packed {
        logic       found;
        logic [2:0] path_row;
        logic [2:0] path_col;
        logic       last;
    } res_t;

    typedef struct packed {
        logic       blocked;
        logic       visited;
        logic [1:0] parent;
    } cell_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic can_push;
        logic can_pop;
    } queue_stat_t;

endpackage

`default_nettype wire

FILE: rtl/gbsp_in_if.sv
`default_nettype none

interface gbsp_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [2:0] row;
    logic [2:0] col;
    logic       blocked;
    logic [2:0] goal_row;
    logic [2:0] goal_col;

    modport source (
        output valid, cmd, row, col, blocked, goal_row, goal_col,
        input  ready
    );
    modport sink (
        input  valid, cmd, row, col, blocked, goal_row, goal_col,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/gbsp_out_if.sv
`default_nettype none

interface gbsp_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [2:0] path_row;
    logic [2:0] path_col;
    logic       last;

    modport source (
        output valid, found, path_row, path_col, last,
        input  ready
    );
    modport sink (
        input  valid, found, path_row, path_col, last,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/gbsp_queue.sv
`default_nettype none

module gbsp_queue
    import gbsp_pkg::*;
#(
    parameter int DEPTH = DEF_GRID_ROWS * DEF_GRID_COLS,
    parameter int W     = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    input  queue_ctrl_t  ctrl,
    input  logic [W-1:0] push_data,
    output logic [W-1:0] pop_data,
    output queue_stat_t  stat
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = AW + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [W-1:0]     queue_mem [DEPTH];
    logic [W-1:0]     pop_data_reg;
    logic [CNT_W-1:0] head_reg;
    logic [CNT_W-1:0] head_next;
    logic [CNT_W-1:0] tail_reg;
    logic [CNT_W-1:0] tail_next;
    logic             do_push;

    assign stat.can_pop  = head_reg < tail_reg;
    assign stat.can_push = tail_reg < DEPTH_C;
    assign do_push       = ctrl.push && stat.can_push;
    assign pop_data      = pop_data_reg;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_mem[tail_reg[AW-1:0]] <= push_data;
        end
        if (ctrl.pop)
        begin
            pop_data_reg <= queue_mem[head_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (ctrl.clear)
        begin
            head_next = '0;
            tail_next = '0;
        end
        else
        begin
            if (ctrl.pop)
            begin
                head_next = head_reg + CNT_W'(1);
            end
            if (do_push)
            begin
                tail_next = tail_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_head_behind_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");
    a_tail_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= DEPTH_C)
        else $error("queue tail beyond depth");
`endif

endmodule

`default_nettype wire

FILE: rtl/gbsp_out_reg.sv
`default_nettype none

module gbsp_out_reg
    import gbsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  res_t             load_data,
    output logic             free,
    gbsp_out_if.source       res
);

    logic valid_reg;
    logic valid_next;
    res_t data_reg;
    res_t data_next;

    assign free         = !valid_reg || res.ready;
    assign res.valid    = valid_reg;
    assign res.found    = data_reg.found;
    assign res.path_row = data_reg.path_row;
    assign res.path_col = data_reg.path_col;
    assign res.last     = data_reg.last;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            data_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            data_reg  <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/grid_bfs_shortest_path.sv
// Shortest path on a GRID_ROWS x GRID_COLS grid by breadth-first search.
// Input channel "item": cmd 0 writes the blocked bit of cell (row, col);
// cmd 1 searches from (row, col) to (goal_row, goal_col).
// Output channel "res": for a search, the path from goal back to start, one
// cell per transfer, last set on the final one; an unreachable goal or a
// start off the grid gives one transfer with found clear.
// After reset the cell memory is swept to zero, one cell a cycle; no item
// is taken during the sweep. A search first clears the visit mark of
// every cell but the start cell, in one read-modify-write pass over the
// cell memory, then handles each dequeued cell (queue read, then four
// neighbor reads of the cell memory, pipelined against their write-back),
// then reads and sends each path cell. One item is worked on at a time; a
// new item is taken once the previous search has handed its last result
// to the output register. A stalled receiver holds the result register
// and the path walk waits on it.
`default_nettype none

module grid_bfs_shortest_path
    import gbsp_pkg::*;
#(
    parameter int GRID_ROWS = DEF_GRID_ROWS,
    parameter int GRID_COLS = DEF_GRID_COLS
) (
    input  logic        clk,
    input  logic        rst_n,
    gbsp_in_if.sink     item,
    gbsp_out_if.source  res
);

    localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
    localparam int RW         = $clog2(GRID_ROWS);
    localparam int CW         = $clog2(GRID_COLS);
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CNT_W      = AW + 1;
    localparam int QW         = RW + CW;
    localparam int PC_W       = $clog2(RESULT_LIMIT);
    localparam logic [CNT_W-1:0] CELL_CNT   = CNT_W'(CELL_COUNT);
    localparam logic [PC_W-1:0]  PATH_LAST  = PC_W'(RESULT_LIMIT - 1);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLEAR = 4'd2;
    localparam logic [3:0] S_SEED  = 4'd3;
    localparam logic [3:0] S_DEQ   = 4'd4;
    localparam logic [3:0] S_DQW   = 4'd5;
    localparam logic [3:0] S_EXP   = 4'd6;
    localparam logic [3:0] S_PRD   = 4'd7;
    localparam logic [3:0] S_PEMIT = 4'd8;
    localparam logic [3:0] S_MISS  = 4'd9;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                 input logic [CW-1:0] c);
        return AW'(32'(r) * GRID_COLS + 32'(c));
    endfunction

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             clr_wv_reg, clr_wv_next;
    logic [AW-1:0]    clr_wa_reg, clr_wa_next;
    logic [RW-1:0]    start_row_reg, start_row_next;
    logic [CW-1:0]    start_col_reg, start_col_next;
    logic [AW-1:0]    start_addr_reg, start_addr_next;
    logic [2:0]       goal_row_reg, goal_row_next;
    logic [2:0]       goal_col_reg, goal_col_next;
    logic [RW-1:0]    cur_row_reg, cur_row_next;
    logic [CW-1:0]    cur_col_reg, cur_col_next;
    logic [2:0]       k_reg, k_next;
    logic             rsp_ok_reg, rsp_ok_next;
    logic [1:0]       rsp_dir_reg, rsp_dir_next;
    logic [AW-1:0]    rsp_addr_reg, rsp_addr_next;
    logic [RW-1:0]    rsp_row_reg, rsp_row_next;
    logic [CW-1:0]    rsp_col_reg, rsp_col_next;
    logic [PC_W-1:0]  pcnt_reg, pcnt_next;

    cell_t            cell_mem [CELL_COUNT];
    cell_t            cell_rd_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    cell_t            mem_wd;
    logic             mem_re;
    logic [AW-1:0]    mem_ra;

    queue_ctrl_t      q_ctrl;
    queue_stat_t      q_stat;
    logic [QW-1:0]    q_push_data;
    logic [QW-1:0]    q_pop_data;
    logic [RW-1:0]    q_row;
    logic [CW-1:0]    q_col;

    logic             out_load;
    res_t             out_data;
    logic             out_free;

    logic             item_fire;
    logic             item_in_grid;
    logic [RW-1:0]    item_row;
    logic [CW-1:0]    item_col;

    logic             nb_ok;
    logic [RW-1:0]    nb_row;
    logic [CW-1:0]    nb_col;
    logic             par_ok;
    logic [RW-1:0]    par_row;
    logic [CW-1:0]    par_col;
    logic             at_start;
    logic             path_end;
    logic             fresh;

    assign item.ready   = (state_reg == S_IDLE);
    assign item_fire    = item.valid && item.ready;
    assign item_in_grid = (32'(item.row) < 32'(GRID_ROWS))
                       && (32'(item.col) < 32'(GRID_COLS));
    assign item_row     = RW'(item.row);
    assign item_col     = CW'(item.col);

    assign q_row = q_pop_data[QW-1:CW];
    assign q_col = q_pop_data[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            cell_rd_reg <= cell_mem[mem_ra];
        end
    end

    // neighbor of the current cell in the direction being issued
    always_comb
    begin
        nb_ok  = 1'b0;
        nb_row = cur_row_reg;
        nb_col = cur_col_reg;
        unique case (k_reg[1:0])
            DIR_UP:
            begin
                nb_ok  = cur_row_reg != '0;
                nb_row = cur_row_reg - RW'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok  = (32'(cur_col_reg) + 32'd1) < 32'(GRID_COLS);
                nb_col = cur_col_reg + CW'(1);
            end
            DIR_DOWN:
            begin
                nb_ok  = (32'(cur_row_reg) + 32'd1) < 32'(GRID_ROWS);
                nb_row = cur_row_reg + RW'(1);
            end
            DIR_LEFT:
            begin
                nb_ok  = cur_col_reg != '0;
                nb_col = cur_col_reg - CW'(1);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // step back against the recorded direction
    always_comb
    begin
        par_ok  = 1'b0;
        par_row = cur_row_reg;
        par_col = cur_col_reg;
        unique case (cell_rd_reg.parent)
            DIR_UP:
            begin
                par_ok  = (32'(cur_row_reg) + 32'd1) < 32'(GRID_ROWS);
                par_row = cur_row_reg + RW'(1);
            end
            DIR_RIGHT:
            begin
                par_ok  = cur_col_reg != '0;
                par_col = cur_col_reg - CW'(1);
            end
            DIR_DOWN:
            begin
                par_ok  = cur_row_reg != '0;
                par_row = cur_row_reg - RW'(1);
            end
            DIR_LEFT:
            begin
                par_ok  = (32'(cur_col_reg) + 32'd1) < 32'(GRID_COLS);
                par_col = cur_col_reg + CW'(1);
            end
            default:
            begin
                par_ok = 1'b0;
            end
        endcase
    end

    assign at_start = (cur_row_reg == start_row_reg) && (cur_col_reg == start_col_reg);
    assign path_end = at_start || (pcnt_reg == PATH_LAST) || !par_ok;
    assign fresh    = rsp_ok_reg && !cell_rd_reg.blocked && !cell_rd_reg.visited;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        clr_wv_next     = 1'b0;
        clr_wa_next     = clr_wa_reg;
        start_row_next  = start_row_reg;
        start_col_next  = start_col_reg;
        start_addr_next = start_addr_reg;
        goal_row_next   = goal_row_reg;
        goal_col_next   = goal_col_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        k_next          = k_reg;
        rsp_ok_next     = 1'b0;
        rsp_dir_next    = rsp_dir_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_row_next    = rsp_row_reg;
        rsp_col_next    = rsp_col_reg;
        pcnt_next       = pcnt_reg;

        mem_we      = 1'b0;
        mem_wa      = clr_wa_reg;
        mem_wd      = '0;
        mem_re      = 1'b0;
        mem_ra      = cnt_reg[AW-1:0];
        q_ctrl      = '0;
        q_push_data = {start_row_reg, start_col_reg};
        out_load    = 1'b0;
        out_data    = '0;

        // write back the visit-clear sweep, one cell behind the read
        if (clr_wv_reg)
        begin
            mem_we         = 1'b1;
            mem_wa         = clr_wa_reg;
            mem_wd.blocked = cell_rd_reg.blocked;
            mem_wd.visited = (clr_wa_reg == start_addr_reg);
            mem_wd.parent  = cell_rd_reg.parent;
        end

        unique case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                mem_wa = cnt_reg[AW-1:0];
                mem_wd = '0;
                if (cnt_reg == CELL_CNT - CNT_W'(1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_IDLE:
            begin
                if (item_fire)
                begin
                    if (!item.cmd)
                    begin
                        if (item_in_grid)
                        begin
                            mem_we         = 1'b1;
                            mem_wa         = cell_addr(item_row, item_col);
                            mem_wd         = '0;
                            mem_wd.blocked = item.blocked;
                        end
                    end
                    else if (!item_in_grid)
                    begin
                        state_next = S_MISS;
                    end
                    else
                    begin
                        start_row_next  = item_row;
                        start_col_next  = item_col;
                        start_addr_next = cell_addr(item_row, item_col);
                        goal_row_next   = item.goal_row;
                        goal_col_next   = item.goal_col;
                        cnt_next        = '0;
                        q_ctrl.clear    = 1'b1;
                        state_next      = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                if (cnt_reg < CELL_CNT)
                begin
                    mem_re      = 1'b1;
                    mem_ra      = cnt_reg[AW-1:0];
                    clr_wv_next = 1'b1;
                    clr_wa_next = cnt_reg[AW-1:0];
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                q_ctrl.push = 1'b1;
                q_push_data = {start_row_reg, start_col_reg};
                state_next  = S_DEQ;
            end
            S_DEQ:
            begin
                if (q_stat.can_pop)
                begin
                    q_ctrl.pop = 1'b1;
                    state_next = S_DQW;
                end
                else
                begin
                    state_next = S_MISS;
                end
            end
            S_DQW:
            begin
                cur_row_next = q_row;
                cur_col_next = q_col;
                if ((32'(q_row) == 32'(goal_row_reg)) && (32'(q_col) == 32'(goal_col_reg)))
                begin
                    pcnt_next  = '0;
                    state_next = S_PRD;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_EXP;
                end
            end
            S_EXP:
            begin
                // issue neighbor k while the response for k-1 comes back
                if (k_reg != 3'd4)
                begin
                    mem_re        = nb_ok;
                    mem_ra        = cell_addr(nb_row, nb_col);
                    rsp_ok_next   = nb_ok;
                    rsp_dir_next  = k_reg[1:0];
                    rsp_addr_next = cell_addr(nb_row, nb_col);
                    rsp_row_next  = nb_row;
                    rsp_col_next  = nb_col;
                end
                if (fresh)
                begin
                    mem_we         = 1'b1;
                    mem_wa         = rsp_addr_reg;
                    mem_wd.blocked = 1'b0;
                    mem_wd.visited = 1'b1;
                    mem_wd.parent  = rsp_dir_reg;
                    q_ctrl.push    = 1'b1;
                    q_push_data    = {rsp_row_reg, rsp_col_reg};
                end
                if (k_reg == 3'd4)
                begin
                    state_next = S_DEQ;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            S_PRD:
            begin
                mem_re     = 1'b1;
                mem_ra     = cell_addr(cur_row_reg, cur_col_reg);
                state_next = S_PEMIT;
            end
            S_PEMIT:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    out_data.found    = 1'b1;
                    out_data.path_row = 3'(cur_row_reg);
                    out_data.path_col = 3'(cur_col_reg);
                    out_data.last     = path_end;
                    if (path_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_row_next = par_row;
                        cur_col_next = par_col;
                        pcnt_next    = pcnt_reg + PC_W'(1);
                        state_next   = S_PRD;
                    end
                end
            end
            S_MISS:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_data      = '0;
                    out_data.last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cnt_reg        <= '0;
            clr_wv_reg     <= 1'b0;
            clr_wa_reg     <= '0;
            start_row_reg  <= '0;
            start_col_reg  <= '0;
            start_addr_reg <= '0;
            goal_row_reg   <= '0;
            goal_col_reg   <= '0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            k_reg          <= '0;
            rsp_ok_reg     <= 1'b0;
            rsp_dir_reg    <= '0;
            rsp_addr_reg   <= '0;
            rsp_row_reg    <= '0;
            rsp_col_reg    <= '0;
            pcnt_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            clr_wv_reg     <= clr_wv_next;
            clr_wa_reg     <= clr_wa_next;
            start_row_reg  <= start_row_next;
            start_col_reg  <= start_col_next;
            start_addr_reg <= start_addr_next;
            goal_row_reg   <= goal_row_next;
            goal_col_reg   <= goal_col_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            k_reg          <= k_next;
            rsp_ok_reg     <= rsp_ok_next;
            rsp_dir_reg    <= rsp_dir_next;
            rsp_addr_reg   <= rsp_addr_next;
            rsp_row_reg    <= rsp_row_next;
            rsp_col_reg    <= rsp_col_next;
            pcnt_reg       <= pcnt_next;
        end
    end

    gbsp_queue #(
        .DEPTH (CELL_COUNT),
        .W     (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q_ctrl),
        .push_data (q_push_data),
        .pop_data  (q_pop_data),
        .stat      (q_stat)
    );

    gbsp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_data (out_data),
        .free      (out_free),
        .res       (res)
    );

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result loaded while output register busy");
    a_no_same_cell_rw: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re && (mem_wa == mem_ra)))
        else $error("cell memory read and written at the same entry");
    a_seed_empty_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEED) |-> !q_stat.can_pop)
        else $error("queue not empty when seeding the start cell");
`endif

endmodule

`default_nettype wire
